>>> rtl/core/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants and elaboration-time table builders for the great-circle
// distance datapath: fixed-point pi, radian factor, CORDIC arctangents, gain.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 30;
  localparam int CORDIC_STAGES_DEF   = 32;

  // Q60 datapath word and helpers
  localparam int VW           = 64;
  localparam int VFRAC        = 60;
  localparam int SQRT_W       = 61;
  localparam int SQRT_STEPS   = 61;
  localparam int QMUL_LAT     = 5;
  localparam int CORDIC_EXTRA = 2;

  localparam logic [63:0]  PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [127:0] RAD92_FULL = {32'd0, PI_Q60, 32'd0} / 128'd1800000000;
  localparam logic [62:0]  RAD92      = RAD92_FULL[62:0];
  localparam logic [31:0]  RAD_LO     = RAD92[31:0];
  localparam logic [30:0]  RAD_HI     = RAD92[62:32];
  localparam logic [32:0]  RADIUS_MM  = 33'd6371008800;
  localparam logic [34:0]  DIST_CAP   = 35'd20015087000;
  localparam logic signed [63:0] ONE_Q = 64'sh1000_0000_0000_0000;

  // Unsigned 64x64 product, rounded half up and shifted right
  function automatic logic [63:0] umulsh(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  // CORDIC gain correction in Q60, Newton iteration on 1/sqrt(prod)
  function automatic logic [63:0] cordic_gain(input int stages);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    int i;
    int k;
    p = 64'd1 << VFRAC;
    for (i = 0; i < stages; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    y = (64'd3 << VFRAC) / 64'd5;
    for (k = 0; k < 8; k++) begin
      t = umulsh(umulsh(p, y, VFRAC), y, VFRAC);
      y = umulsh(y, (64'd3 << VFRAC) - t, VFRAC + 1);
    end
    return y;
  endfunction

  // atan(2^-i) from its power series in Q62, rounded to frac bits
  function automatic logic [63:0] atan_q(input int i, input int frac);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    int s;
    s = 62 - frac;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      sum = 64'd0;
      k   = 0;
      while (i * (2 * k + 1) <= 62) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k[0]) sum = sum - term;
        else sum = sum + term;
        k++;
      end
    end
    return (sum + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] pi_ang(input int frac);
    return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
  endfunction

  function automatic logic [63:0] half_pi_ang(input int frac);
    return (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
  endfunction

endpackage

>>> rtl/core/gcd_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_qmul
// Pipelined signed Q60 multiplier: sign-magnitude, four 32x32 partial
// products, rounded half away from zero. Five register stages.
// ----------------------------------------------------------------------------
module gcd_qmul (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gcd_pkg::VW-1:0] a,
  input  logic signed [gcd_pkg::VW-1:0] b,
  output logic signed [gcd_pkg::VW-1:0] p
);
  import gcd_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  ll;
  logic [63:0]  lh;
  logic [63:0]  hl;
  logic [63:0]  hh;
  logic [64:0]  mid;
  logic [63:0]  ll2;
  logic [63:0]  hh2;
  logic [62:0]  rnd;
  logic [3:0]   sg;
  logic [127:0] tot;

  // Recombine partial products and add the rounding half
  assign tot = {hh2, ll2} + {31'd0, mid, 32'd0} + (128'd1 << (VFRAC - 1));

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      ma    <= a[63] ? 64'(-a) : 64'(a);
      mb    <= b[63] ? 64'(-b) : 64'(b);
      sg[0] <= a[63] ^ b[63];
      ll    <= {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
      lh    <= {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
      hl    <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
      hh    <= {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
      sg[1] <= sg[0];
      mid   <= {1'b0, lh} + {1'b0, hl};
      ll2   <= ll;
      hh2   <= hh;
      sg[2] <= sg[1];
      rnd   <= tot[VFRAC +: 63];
      sg[3] <= sg[2];
      p     <= sg[3] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    end
  end

endmodule

>>> rtl/core/gcd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_cordic
// Unrolled CORDIC, one iteration per register stage. Rotation mode brings
// the angle into [-pi/2, pi/2] first; vectoring mode clamps a negative angle.
// ----------------------------------------------------------------------------
module gcd_cordic #(
  parameter int FRAC   = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [gcd_pkg::VW-1:0] x_in,
  input  logic signed [gcd_pkg::VW-1:0] y_in,
  input  logic signed [FRAC+3:0]        z_in,
  output logic signed [gcd_pkg::VW-1:0] x_out,
  output logic signed [gcd_pkg::VW-1:0] y_out,
  output logic signed [FRAC+3:0]        z_out
);
  import gcd_pkg::*;

  localparam int AW = FRAC + 4;

  function automatic logic [STAGES*AW-1:0] atf_table();
    logic [STAGES*AW-1:0] t;
    int i;
    t = '0;
    for (i = 0; i < STAGES; i++) t[i*AW +: AW] = AW'(atan_q(i, FRAC));
    return t;
  endfunction

  localparam logic [STAGES*AW-1:0] ATF_TAB = atf_table();
  localparam logic signed [AW-1:0] PI_A    = AW'(pi_ang(FRAC));
  localparam logic signed [AW-1:0] HALF_A  = AW'(half_pi_ang(FRAC));

  logic signed [VW-1:0] xr     [0:STAGES];
  logic signed [VW-1:0] yr     [0:STAGES];
  logic signed [AW-1:0] zr     [0:STAGES];
  logic [STAGES:0]      ng;
  logic signed [VW-1:0] x_next [0:STAGES-1];
  logic signed [VW-1:0] y_next [0:STAGES-1];
  logic signed [AW-1:0] z_next [0:STAGES-1];

  // One micro-rotation per stage
  always_comb begin
    logic signed [VW-1:0] xsh;
    logic signed [VW-1:0] ysh;
    logic                 pos;
    for (int i = 0; i < STAGES; i++) begin
      xsh = xr[i] >>> i;
      ysh = yr[i] >>> i;
      pos = VECTOR ? yr[i][VW-1] : !zr[i][AW-1];
      if (pos) begin
        x_next[i] = xr[i] - ysh;
        y_next[i] = yr[i] + xsh;
        z_next[i] = zr[i] - signed'(ATF_TAB[i*AW +: AW]);
      end else begin
        x_next[i] = xr[i] + ysh;
        y_next[i] = yr[i] - xsh;
        z_next[i] = zr[i] + signed'(ATF_TAB[i*AW +: AW]);
      end
    end
  end

  // Load, iterate and correct the result
  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= x_in;
      yr[0] <= y_in;
      if (!VECTOR && z_in > HALF_A) begin
        zr[0] <= z_in - PI_A;
        ng[0] <= 1'b1;
      end else if (!VECTOR && z_in < -HALF_A) begin
        zr[0] <= z_in + PI_A;
        ng[0] <= 1'b1;
      end else begin
        zr[0] <= z_in;
        ng[0] <= 1'b0;
      end
      for (int i = 0; i < STAGES; i++) begin
        xr[i+1] <= x_next[i];
        yr[i+1] <= y_next[i];
        zr[i+1] <= z_next[i];
        ng[i+1] <= ng[i];
      end
      if (VECTOR) begin
        x_out <= xr[STAGES];
        y_out <= yr[STAGES];
        z_out <= zr[STAGES][AW-1] ? '0 : zr[STAGES];
      end else begin
        x_out <= ng[STAGES] ? -xr[STAGES] : xr[STAGES];
        y_out <= ng[STAGES] ? -yr[STAGES] : yr[STAGES];
        z_out <= zr[STAGES];
      end
    end
  end

endmodule

>>> rtl/core/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine distance between two points given in degrees times 1e7, on a
// sphere of radius 6371008.8 m, returned in millimetres.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries lat_a, lon_a, lat_b, lon_b and is taken when in_valid
//   is high and in_stall is low. Each request yields exactly one result on
//   distance_mm, offered with out_valid and taken when out_stall is low.
//   The pipeline runs four rotation CORDICs, the Q60 products, two
//   61-step square roots and a vectoring CORDIC, each built as one
//   register stage per step. It takes one request per cycle while
//   out_stall does not hold it, and holds up to one request in each
//   of its LAT valid-flag stages at once.
//   When a result waits and out_stall is high, every stage holds and
//   in_stall rises in the same cycle; bubbles inside do not hold anything.
//   Reset clears all valid flags; the data registers are not reset.
//   Results saturate at 20015087000 mm.
// ----------------------------------------------------------------------------
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [34:0] distance_mm
);
  import gcd_pkg::*;

  localparam int AW  = ANGLE_FRAC_BITS + 4;
  localparam int LAT = 2 * (CORDIC_STAGES + CORDIC_EXTRA) + 2 * QMUL_LAT + SQRT_STEPS + 7;
  localparam int SH_LAT = 92 - ANGLE_FRAC_BITS;
  localparam int SH_DIF = 93 - ANGLE_FRAC_BITS;
  localparam logic signed [VW-1:0] GAIN = VW'(cordic_gain(CORDIC_STAGES));

  logic                 adv;
  logic [LAT-1:0]       vld;
  logic [32:0]          lane_val [0:3];
  logic [32:0]          mag      [0:3];
  logic [3:0]           sg0;
  logic [3:0]           sg1;
  logic [64:0]          pl       [0:3];
  logic [63:0]          ph       [0:3];
  logic signed [AW-1:0] ang      [0:3];
  logic signed [AW-1:0] ang_next [0:3];
  logic signed [VW-1:0] cos_a;
  logic signed [VW-1:0] cos_b;
  logic signed [VW-1:0] sin_dlat;
  logic signed [VW-1:0] sin_dlon;
  logic signed [VW-1:0] s1sq;
  logic signed [VW-1:0] cacb;
  logic signed [VW-1:0] s2sq;
  logic signed [VW-1:0] prod;
  logic signed [VW-1:0] s1d      [0:QMUL_LAT-1];
  logic signed [VW-1:0] a_sum;
  logic signed [VW-1:0] a_cl;
  logic [SQRT_W-1:0]    sq_rad   [0:1][0:SQRT_STEPS];
  logic [63:0]          sq_rem   [0:1][0:SQRT_STEPS];
  logic [SQRT_W-1:0]    sq_root  [0:1][0:SQRT_STEPS];
  logic [63:0]          rem_next [0:1][0:SQRT_STEPS-1];
  logic [SQRT_W-1:0]    root_next[0:1][0:SQRT_STEPS-1];
  logic signed [AW-1:0] z_v;
  logic [63:0]          tz;
  logic [64:0]          fm_lo;
  logic [64:0]          fm_hi;
  logic [127:0]         fsum;
  logic [63:0]          dv;

  // Hold the whole pipeline while a result waits on a stalled receiver
  assign in_stall  = out_valid && out_stall;
  assign adv       = !in_stall;
  assign out_valid = vld[LAT-1];

  // Advance the valid flags with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Latitudes and coordinate differences, widened
  assign lane_val[0] = 33'(lat_a);
  assign lane_val[1] = 33'(lat_b);
  assign lane_val[2] = 33'(lat_b) - 33'(lat_a);
  assign lane_val[3] = 33'(lon_b) - 33'(lon_a);

  // Round the scaled product to an angle and restore the sign
  always_comb begin
    logic [96:0] full;
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        full = {32'd0, pl[l]} + {1'b0, ph[l], 32'd0} + (97'd1 << (SH_LAT - 1));
        full = full >> SH_LAT;
      end else begin
        full = {32'd0, pl[l]} + {1'b0, ph[l], 32'd0} + (97'd1 << (SH_DIF - 1));
        full = full >> SH_DIF;
      end
      ang_next[l] = sg1[l] ? -signed'(full[AW-1:0]) : signed'(full[AW-1:0]);
    end
  end

  // Degree to radian conversion over three stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        mag[l]   <= lane_val[l][32] ? -lane_val[l] : lane_val[l];
        sg0[l]   <= lane_val[l][32];
        pl[l]    <= {32'd0, mag[l]} * {33'd0, RAD_LO};
        ph[l]    <= 64'({31'd0, mag[l]} * {33'd0, RAD_HI});
        sg1[l]   <= sg0[l];
        ang[l]   <= ang_next[l];
      end
    end
  end

  gcd_cordic #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_la (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(ang[0]),
    .x_out(cos_a), .y_out(), .z_out()
  );

  gcd_cordic #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_lb (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(ang[1]),
    .x_out(cos_b), .y_out(), .z_out()
  );

  gcd_cordic #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_dlat (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(ang[2]),
    .x_out(), .y_out(sin_dlat), .z_out()
  );

  gcd_cordic #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_dlon (
    .clk(clk), .en(adv), .x_in(GAIN), .y_in('0), .z_in(ang[3]),
    .x_out(), .y_out(sin_dlon), .z_out()
  );

  gcd_qmul u_mul_s1 (.clk(clk), .en(adv), .a(sin_dlat), .b(sin_dlat), .p(s1sq));
  gcd_qmul u_mul_cc (.clk(clk), .en(adv), .a(cos_a), .b(cos_b), .p(cacb));
  gcd_qmul u_mul_s2 (.clk(clk), .en(adv), .a(sin_dlon), .b(sin_dlon), .p(s2sq));
  gcd_qmul u_mul_hv (.clk(clk), .en(adv), .a(cacb), .b(s2sq), .p(prod));

  // Clamp the haversine term to [0, 1]
  assign a_cl = a_sum[VW-1] ? '0 : ((a_sum > ONE_Q) ? ONE_Q : a_sum);

  // Delay sin^2(dlat/2) to meet the second product, then sum
  always_ff @(posedge clk) begin
    if (adv) begin
      s1d[0] <= s1sq;
      for (int k = 1; k < QMUL_LAT; k++) s1d[k] <= s1d[k-1];
      a_sum <= s1d[QMUL_LAT-1] + prod;
    end
  end

  // Restoring square root, one result bit per stage
  always_comb begin
    logic [2*SQRT_W-1+1:0] nrad;
    logic [65:0]           tr;
    logic [65:0]           trial;
    logic                  ge;
    for (int u = 0; u < 2; u++) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        nrad  = {1'b0, sq_rad[u][k], 60'd0};
        tr    = {sq_rem[u][k], nrad[2*(SQRT_STEPS-1-k) +: 2]};
        trial = {3'd0, sq_root[u][k], 2'b01};
        ge    = (tr >= trial);
        rem_next[u][k]  = ge ? 64'(tr - trial) : 64'(tr);
        root_next[u][k] = {sq_root[u][k][SQRT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rad[0][0]  <= SQRT_W'(ONE_Q - a_cl);
      sq_rad[1][0]  <= SQRT_W'(a_cl);
      for (int u = 0; u < 2; u++) begin
        sq_rem[u][0]  <= '0;
        sq_root[u][0] <= '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
          sq_rad[u][k+1]  <= sq_rad[u][k];
          sq_rem[u][k+1]  <= rem_next[u][k];
          sq_root[u][k+1] <= root_next[u][k];
        end
      end
    end
  end

  gcd_cordic #(.FRAC(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_vec (
    .clk(clk), .en(adv),
    .x_in({3'd0, sq_root[0][SQRT_STEPS]}),
    .y_in({3'd0, sq_root[1][SQRT_STEPS]}),
    .z_in('0),
    .x_out(), .y_out(), .z_out(z_v)
  );

  // Twice the central angle, scaled by the radius, rounded half up
  assign tz   = {{(64-AW){1'b0}}, z_v[AW-2:0], 1'b0};
  assign fsum = {63'd0, fm_lo} + {31'd0, fm_hi, 32'd0} + (128'd1 << (ANGLE_FRAC_BITS - 1));
  assign dv   = fsum[ANGLE_FRAC_BITS +: 64];

  always_ff @(posedge clk) begin
    if (adv) begin
      fm_lo <= {32'd0, tz[31:0]} * {32'd0, RADIUS_MM};
      fm_hi <= {32'd0, tz[63:32]} * {32'd0, RADIUS_MM};
      distance_mm <= (dv > {29'd0, DIST_CAP}) ? DIST_CAP : dv[34:0];
    end
  end

  // A result never exceeds half the circumference
  assert property (@(posedge clk) disable iff (rst) out_valid |-> distance_mm <= DIST_CAP)
    else $error("distance above saturation limit");

  // A held pipeline keeps every valid flag in place
  assert property (@(posedge clk) disable iff (rst) in_stall |=> vld == $past(vld))
    else $error("pipeline moved while held");

  // An accepted request enters the first stage
  assert property (@(posedge clk) disable iff (rst) !in_stall |=> vld[0] == $past(in_valid))
    else $error("request lost at pipeline entry");

endmodule
